FILE: src/zlib_stored_block_framer_top_defines.svh
// Assertion helpers shared by the framer modules.
`ifndef ZLIB_STORED_BLOCK_FRAMER_TOP_DEFINES_SVH
`define ZLIB_STORED_BLOCK_FRAMER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZSBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZSBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/zsbf_pkg.sv
package zsbf_pkg;

    localparam int unsigned MAX_MESSAGE_BYTES = 65535;
    localparam int unsigned QUEUE_DEPTH       = 4;

    localparam logic [15:0] ADLER_MOD    = 16'd65521;
    localparam logic [7:0]  ZLIB_CMF     = 8'h78;
    localparam logic [7:0]  ZLIB_FLG     = 8'h01;
    localparam logic [7:0]  STORED_FINAL = 8'h01;

    // One queued job: which parts of the stream a single input item produces.
    typedef struct packed {
        logic        has_header;
        logic        has_data;
        logic        has_trailer;
        logic [7:0]  data_byte;
        logic [15:0] length;
        logic [31:0] checksum;
    } cmd_t;

    // Reduction of a sum that is known to stay below twice the modulus.
    function automatic logic [15:0] adler_reduce(input logic [16:0] s);
        logic [16:0] d;
        begin
            d = s - {1'b0, ADLER_MOD};
            adler_reduce = (s >= {1'b0, ADLER_MOD}) ? d[15:0] : s[15:0];
        end
    endfunction

endpackage

FILE: src/zsbf_front.sv
module zsbf_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 first_of_message,
    input  logic                 last_of_message,
    input  logic [15:0]          message_length,
    input  logic                 empty_message,
    input  logic                 q_full,
    output logic                 q_push,
    output zsbf_pkg::cmd_t       q_cmd
);

    logic [15:0] sum_low_reg, sum_low_next;
    logic [15:0] sum_high_reg, sum_high_next;
    logic [15:0] base_low, base_high;
    logic [15:0] new_low, new_high;
    logic [15:0] len_sat;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // A header restarts the checksum before the byte is added.
    assign base_low  = first_of_message ? 16'd1 : sum_low_reg;
    assign base_high = first_of_message ? 16'd0 : sum_high_reg;
    assign new_low   = zsbf_pkg::adler_reduce({1'b0, base_low} + {9'd0, data_byte});
    assign new_high  = zsbf_pkg::adler_reduce({1'b0, base_high} + {1'b0, new_low});

    assign len_sat = (message_length > 16'(zsbf_pkg::MAX_MESSAGE_BYTES))
                   ? 16'(zsbf_pkg::MAX_MESSAGE_BYTES) : message_length;

    always_comb
    begin
        if (empty_message)
        begin
            q_cmd.has_header  = 1'b1;
            q_cmd.has_data    = 1'b0;
            q_cmd.has_trailer = 1'b1;
            q_cmd.data_byte   = data_byte;
            q_cmd.length      = 16'd0;
            q_cmd.checksum    = 32'd1;
        end
        else
        begin
            q_cmd.has_header  = first_of_message;
            q_cmd.has_data    = 1'b1;
            q_cmd.has_trailer = last_of_message;
            q_cmd.data_byte   = data_byte;
            q_cmd.length      = len_sat;
            q_cmd.checksum    = {new_high, new_low};
        end
    end

    always_comb
    begin
        sum_low_next  = sum_low_reg;
        sum_high_next = sum_high_reg;
        if (accept)
        begin
            if (empty_message || last_of_message)
            begin
                sum_low_next  = 16'd1;
                sum_high_next = 16'd0;
            end
            else
            begin
                sum_low_next  = new_low;
                sum_high_next = new_high;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_low_reg  <= 16'd1;
            sum_high_reg <= 16'd0;
        end
        else
        begin
            sum_low_reg  <= sum_low_next;
            sum_high_reg <= sum_high_next;
        end
    end

endmodule

FILE: src/zsbf_fifo.sv
`include "zlib_stored_block_framer_top_defines.svh"

module zsbf_fifo
#(
    parameter int unsigned DEPTH = zsbf_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  zsbf_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output zsbf_pkg::cmd_t pop_data,
    output logic           empty
);

    localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    zsbf_pkg::cmd_t mem [DEPTH];

    logic [IdxW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full     = (count_reg == CntW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `ZSBF_ASSERT_NOW(a_no_pop_when_empty, pop, count_reg != '0, "queue popped while empty")
    `ZSBF_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= CntW'(DEPTH), "queue count overflow")

endmodule

FILE: src/zsbf_back.sv
`include "zlib_stored_block_framer_top_defines.svh"

module zsbf_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  zsbf_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           last_of_run,
    output logic           end_of_stream
);

    typedef enum logic [11:0] {
        PH_CMF     = 12'b0000_0000_0001,
        PH_FLG     = 12'b0000_0000_0010,
        PH_BTYPE   = 12'b0000_0000_0100,
        PH_LEN_LO  = 12'b0000_0000_1000,
        PH_LEN_HI  = 12'b0000_0001_0000,
        PH_NLEN_LO = 12'b0000_0010_0000,
        PH_NLEN_HI = 12'b0000_0100_0000,
        PH_DATA    = 12'b0000_1000_0000,
        PH_ADL3    = 12'b0001_0000_0000,
        PH_ADL2    = 12'b0010_0000_0000,
        PH_ADL1    = 12'b0100_0000_0000,
        PH_ADL0    = 12'b1000_0000_0000
    } phase_t;

    zsbf_pkg::cmd_t cur_reg, cur_next;
    phase_t         phase_reg, phase_next, phase_after, phase_start;
    logic           busy_reg, busy_next;
    logic           ov_reg, ov_next;
    logic [7:0]     ob_reg, ob_next;
    logic           olr_reg, olr_next;
    logic           oes_reg, oes_next;
    logic           advance, done, load;
    logic [7:0]     byte_sel;

    assign advance = busy_reg && (!ov_reg || out_ready);
    assign done    = (phase_reg == PH_ADL0) || ((phase_reg == PH_DATA) && !cur_reg.has_trailer);
    assign load    = !q_empty && (!busy_reg || (advance && done));
    assign q_pop   = load;

    always_comb
    begin
        if (q_cmd.has_header)
        begin
            phase_start = PH_CMF;
        end
        else if (q_cmd.has_data)
        begin
            phase_start = PH_DATA;
        end
        else
        begin
            phase_start = PH_ADL3;
        end
    end

    always_comb
    begin
        case (phase_reg)
            PH_CMF:     phase_after = PH_FLG;
            PH_FLG:     phase_after = PH_BTYPE;
            PH_BTYPE:   phase_after = PH_LEN_LO;
            PH_LEN_LO:  phase_after = PH_LEN_HI;
            PH_LEN_HI:  phase_after = PH_NLEN_LO;
            PH_NLEN_LO: phase_after = PH_NLEN_HI;
            PH_NLEN_HI: phase_after = cur_reg.has_data ? PH_DATA : PH_ADL3;
            PH_DATA:    phase_after = PH_ADL3;
            PH_ADL3:    phase_after = PH_ADL2;
            PH_ADL2:    phase_after = PH_ADL1;
            PH_ADL1:    phase_after = PH_ADL0;
            PH_ADL0:    phase_after = PH_CMF;
            default:    phase_after = PH_CMF;
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PH_CMF:     byte_sel = zsbf_pkg::ZLIB_CMF;
            PH_FLG:     byte_sel = zsbf_pkg::ZLIB_FLG;
            PH_BTYPE:   byte_sel = zsbf_pkg::STORED_FINAL;
            PH_LEN_LO:  byte_sel = cur_reg.length[7:0];
            PH_LEN_HI:  byte_sel = cur_reg.length[15:8];
            PH_NLEN_LO: byte_sel = ~cur_reg.length[7:0];
            PH_NLEN_HI: byte_sel = ~cur_reg.length[15:8];
            PH_DATA:    byte_sel = cur_reg.data_byte;
            PH_ADL3:    byte_sel = cur_reg.checksum[31:24];
            PH_ADL2:    byte_sel = cur_reg.checksum[23:16];
            PH_ADL1:    byte_sel = cur_reg.checksum[15:8];
            PH_ADL0:    byte_sel = cur_reg.checksum[7:0];
            default:    byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        cur_next   = cur_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        if (load)
        begin
            cur_next   = q_cmd;
            phase_next = phase_start;
            busy_next  = 1'b1;
        end
        else if (advance)
        begin
            phase_next = phase_after;
            busy_next  = !done;
        end
    end

    // While a job is busy, the output register takes a byte whenever it is empty or being drained.
    always_comb
    begin
        ov_next  = ov_reg;
        ob_next  = ob_reg;
        olr_next = olr_reg;
        oes_next = oes_reg;
        if (advance)
        begin
            ov_next  = 1'b1;
            ob_next  = byte_sel;
            olr_next = done;
            oes_next = (phase_reg == PH_ADL0);
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CMF;
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ob_reg  <= ob_next;
        olr_reg <= olr_next;
        oes_reg <= oes_next;
    end

    assign out_valid     = ov_reg;
    assign out_byte      = ob_reg;
    assign last_of_run   = olr_reg;
    assign end_of_stream = oes_reg;

    `ZSBF_ASSERT_NOW(a_eos_ends_run, ov_reg && oes_reg, olr_reg, "stream end without run end")
    `ZSBF_ASSERT_NOW(a_data_phase_has_data, busy_reg && (phase_reg == PH_DATA), cur_reg.has_data,
        "data phase for a job without data")
    `ZSBF_ASSERT_NEXT(a_advance_fills_output, advance, ov_reg, "advanced byte not presented")

endmodule

FILE: src/zlib_stored_block_framer_top.sv
// zlib stored-block framer: wraps each message as a zlib stream with one final stored block.
// Input channel s_axis: one transfer per payload byte; tuser[0] marks the first byte, which
// also carries the message length, tlast marks the last byte, and tuser[1] alone stands for
// a whole empty message. Output channel m_axis: one transfer per stream byte; tlast closes
// the bytes that one input transfer produced, tuser[0] marks the final checksum byte.
// A first byte yields seven header bytes and the data byte; a last byte adds four Adler-32
// bytes, big-endian; an empty message yields eleven bytes.
// The first byte for an input passes the queue, the job register, then the output register.
// The back end sends one byte per cycle unless m_axis_tready stalls it, so an input that
// makes one byte is taken every cycle; header or trailer inputs hold it until all are sent.
// A queue of QUEUE_DEPTH jobs decouples the checksum front end from the byte sequencer, so
// input keeps flowing while output stalls until the queue fills; then s_axis_tready drops.
// A stalled output holds its byte and flags unchanged.
// Reset clears the queue and output register and restarts the checksum at one and zero.
module zlib_stored_block_framer_top
#(
    parameter int unsigned QUEUE_DEPTH = zsbf_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_byte [7:0], message_length [23:8]
    input  logic [1:0]  s_axis_tuser,  // first_of_message [0], empty_message [1]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte [7:0]
    output logic [0:0]  m_axis_tuser,  // end_of_stream [0]
    output logic        m_axis_tlast
);

    zsbf_pkg::cmd_t push_cmd, pop_cmd;
    logic           q_push, q_pop, q_full, q_empty;

    zsbf_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .data_byte        (s_axis_tdata[7:0]),
        .first_of_message (s_axis_tuser[0]),
        .last_of_message  (s_axis_tlast),
        .message_length   (s_axis_tdata[23:8]),
        .empty_message    (s_axis_tuser[1]),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (push_cmd)
    );

    zsbf_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_cmd),
        .empty     (q_empty)
    );

    zsbf_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .last_of_run   (m_axis_tlast),
        .end_of_stream (m_axis_tuser[0])
    );

endmodule
